FILE: rtl/core/pcxrle_pkg.sv
// shared types, constants and helpers for the run-length line encoder
package pcxrle_pkg;

    localparam int unsigned SAMPLE_W    = 8;
    localparam int unsigned RUN_W       = 6;
    localparam int unsigned SLOT_N      = 5;
    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [SAMPLE_W-1:0] RUN_MARK = 8'hC0;
    localparam logic [RUN_W-1:0]    RUN_MAX  = 6'd63;
    localparam logic [SAMPLE_W-1:0] PAD_BYTE = 8'h00;

    // byte slot positions inside one job, in output order
    localparam int unsigned SLOT_A_HDR = 0;
    localparam int unsigned SLOT_A_VAL = 1;
    localparam int unsigned SLOT_B_HDR = 2;
    localparam int unsigned SLOT_B_VAL = 3;
    localparam int unsigned SLOT_PAD   = 4;

    typedef struct packed {
        logic [SLOT_N-1:0]   slots;
        logic [SAMPLE_W-1:0] a_hdr;
        logic [SAMPLE_W-1:0] a_val;
        logic [SAMPLE_W-1:0] b_hdr;
        logic [SAMPLE_W-1:0] b_val;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [SAMPLE_W-1:0] f_run_hdr(input logic [RUN_W-1:0] count);
        f_run_hdr = RUN_MARK | {{(SAMPLE_W-RUN_W){1'b0}}, count};
    endfunction

    function automatic logic f_is_literal(input logic [SAMPLE_W-1:0] value,
                                          input logic [RUN_W-1:0]    count);
        f_is_literal = (count == RUN_W'(1)) && (value[7:6] != 2'b11);
    endfunction

endpackage

FILE: rtl/core/pcxrle_front.sv
// front part: keeps the run state and turns each request into a byte job
module pcxrle_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic [pcxrle_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                            i_line_end,
    output logic                            o_push,
    output pcxrle_pkg::t_job                o_job
);
    import pcxrle_pkg::*;

    logic [SAMPLE_W-1:0] r_held, n_held;
    logic [RUN_W-1:0]    r_len, n_len;
    logic                r_started, n_started;
    logic                r_odd, n_odd;

    logic [RUN_W-1:0]    w_inc;
    logic                w_a_en, w_b_en, w_pad;
    logic [SAMPLE_W-1:0] w_a_val, w_b_val;
    logic [RUN_W-1:0]    w_a_cnt, w_b_cnt;

    always_comb begin
        n_held    = r_held;
        n_len     = r_len;
        n_started = r_started;
        n_odd     = r_odd;
        w_inc     = r_len + RUN_W'(1);
        w_a_en    = 1'b0;
        w_a_val   = r_held;
        w_a_cnt   = r_len;
        w_b_en    = 1'b0;
        w_b_val   = '0;
        w_b_cnt   = '0;
        w_pad     = 1'b0;
        if (i_accept) begin
            if (!r_started) begin
                n_held    = i_sample;
                n_len     = RUN_W'(1);
                n_started = 1'b1;
            end else if (i_sample == r_held) begin
                if (w_inc == RUN_MAX) begin
                    w_a_en  = 1'b1;
                    w_a_cnt = RUN_MAX;
                    n_len   = '0;
                end else begin
                    n_len = w_inc;
                end
            end else begin
                w_a_en = (r_len != '0);
                n_held = i_sample;
                n_len  = RUN_W'(1);
            end
            n_odd = ~r_odd;
            if (i_line_end) begin
                w_b_en    = (n_len != '0);
                w_b_val   = n_held;
                w_b_cnt   = n_len;
                w_pad     = n_odd;
                n_held    = '0;
                n_len     = '0;
                n_started = 1'b0;
                n_odd     = 1'b0;
            end
        end
    end

    always_comb begin
        o_job.slots             = '0;
        o_job.slots[SLOT_A_HDR] = w_a_en && !f_is_literal(w_a_val, w_a_cnt);
        o_job.slots[SLOT_A_VAL] = w_a_en;
        o_job.slots[SLOT_B_HDR] = w_b_en && !f_is_literal(w_b_val, w_b_cnt);
        o_job.slots[SLOT_B_VAL] = w_b_en;
        o_job.slots[SLOT_PAD]   = w_pad;
        o_job.a_hdr             = f_run_hdr(w_a_cnt);
        o_job.a_val             = w_a_val;
        o_job.b_hdr             = f_run_hdr(w_b_cnt);
        o_job.b_val             = w_b_val;
    end

    assign o_push = i_accept && (o_job.slots != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held    <= '0;
            r_len     <= '0;
            r_started <= 1'b0;
            r_odd     <= 1'b0;
        end else begin
            r_held    <= n_held;
            r_len     <= n_len;
            r_started <= n_started;
            r_odd     <= n_odd;
        end
    end

endmodule

FILE: rtl/core/pcxrle_queue.sv
// short job queue between the front and back parts
module pcxrle_queue #(
    parameter int unsigned P_DEPTH = pcxrle_pkg::QUEUE_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  pcxrle_pkg::t_job       i_job,
    input  logic                   i_pop,
    output pcxrle_pkg::t_job       o_job,
    output pcxrle_pkg::t_q_status  o_status
);
    import pcxrle_pkg::*;

    localparam int unsigned PTR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(P_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(P_DEPTH - 1);

    t_job             r_mem [P_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_do_push, w_do_pop;

    assign o_status.full  = (r_count == CNT_W'(P_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign w_do_push      = i_push && !o_status.full;
    assign w_do_pop       = i_pop && !o_status.empty;
    assign o_job          = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!w_do_push && w_do_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

FILE: rtl/core/pcxrle_back.sv
// back part: plays out the bytes of each job one per cycle while i_tready is high
module pcxrle_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pcxrle_pkg::t_job                i_job,
    input  pcxrle_pkg::t_q_status           i_q_status,
    output logic                            o_pop,
    output logic                            o_tvalid,
    input  logic                            i_tready,
    output logic [pcxrle_pkg::SAMPLE_W-1:0] o_code_byte,
    output logic                            o_last,
    output logic                            o_pad
);
    import pcxrle_pkg::*;

    logic [SLOT_N-1:0]   r_slots, n_slots;
    logic [SAMPLE_W-1:0] r_a_hdr, r_a_val, r_b_hdr, r_b_val;
    logic [SLOT_N-1:0]   w_low;
    logic                w_take, w_load;

    assign w_low    = r_slots & (~r_slots + SLOT_N'(1));
    assign o_tvalid = (r_slots != '0);
    assign o_last   = ((r_slots & (r_slots - SLOT_N'(1))) == '0);
    assign o_pad    = w_low[SLOT_PAD];
    assign w_take   = o_tvalid && i_tready;
    assign w_load   = (!o_tvalid || (w_take && o_last));
    assign o_pop    = w_load && !i_q_status.empty;

    always_comb begin
        if (w_low[SLOT_A_HDR]) begin
            o_code_byte = r_a_hdr;
        end else if (w_low[SLOT_A_VAL]) begin
            o_code_byte = r_a_val;
        end else if (w_low[SLOT_B_HDR]) begin
            o_code_byte = r_b_hdr;
        end else if (w_low[SLOT_B_VAL]) begin
            o_code_byte = r_b_val;
        end else begin
            o_code_byte = PAD_BYTE;
        end
    end

    always_comb begin
        n_slots = r_slots;
        if (o_pop) begin
            n_slots = i_job.slots;
        end else if (w_load) begin
            n_slots = '0;
        end else if (w_take) begin
            n_slots = r_slots & ~w_low;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_a_hdr <= i_job.a_hdr;
            r_a_val <= i_job.a_val;
            r_b_hdr <= i_job.b_hdr;
            r_b_val <= i_job.b_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots <= '0;
        end else begin
            r_slots <= n_slots;
        end
    end

endmodule

FILE: rtl/core/pcx_rle_line_encoder_unit.sv
// Run-length line encoder: takes one 8-bit sample per request with a line-end mark in
// tlast, and sends encoded bytes (literal, count 0xC0|n, run value, or a zero pad on odd
// line lengths, flagged in tuser) with tlast on the final byte caused by each sample.
// A sample is taken in the cycle it arrives while the job queue has room; the output
// sends one byte per cycle while tready is high, and the bytes a sample causes
// are none inside a run, one or two when a run closes or reaches 63 mid-line, up to
// five at a line end. The byte output port sets the sustained rate; a new job is written
// into the queue, then loaded into the back part once that is idle or taking its last byte.
module pcx_rle_line_encoder_unit #(
    parameter int unsigned P_QUEUE_DEPTH = pcxrle_pkg::QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [pcxrle_pkg::SAMPLE_W-1:0] i_s_axis_tdata,  // [7:0] sample
    input  logic                            i_s_axis_tlast,  // line_end
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [pcxrle_pkg::SAMPLE_W-1:0] o_m_axis_tdata,  // [7:0] code_byte
    output logic                            o_m_axis_tlast,  // last_of_item
    output logic                            o_m_axis_tuser   // [0] pad_flag
);
    import pcxrle_pkg::*;

    logic      w_accept;
    logic      w_push, w_pop;
    t_job      w_push_job, w_pop_job;
    t_q_status w_q_status;

    assign o_s_axis_tready = !w_q_status.full;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    pcxrle_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_sample   (i_s_axis_tdata),
        .i_line_end (i_s_axis_tlast),
        .o_push     (w_push),
        .o_job      (w_push_job)
    );

    pcxrle_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_push_job),
        .i_pop    (w_pop),
        .o_job    (w_pop_job),
        .o_status (w_q_status)
    );

    pcxrle_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_pop_job),
        .i_q_status  (w_q_status),
        .o_pop       (w_pop),
        .o_tvalid    (o_m_axis_tvalid),
        .i_tready    (i_m_axis_tready),
        .o_code_byte (o_m_axis_tdata),
        .o_last      (o_m_axis_tlast),
        .o_pad       (o_m_axis_tuser)
    );

`ifndef SYNTHESIS
    a_no_push_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_q_status.full))
        else $error("job pushed into a full queue");

    a_no_pop_when_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_pop && w_q_status.empty))
        else $error("job popped from an empty queue");

    a_pad_is_zero_and_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tlast && (o_m_axis_tdata == PAD_BYTE)))
        else $error("pad byte not zero or not last of its request");

    a_pop_needs_idle_output : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> (!o_m_axis_tvalid || (i_m_axis_tready && o_m_axis_tlast)))
        else $error("new job loaded while bytes of the current one remain");
`endif

endmodule
